@@ design/hex8_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hex8_pkg: shared types and constants of the brick element stiffness block
// Field structs, config struct, queue entry, builder states and node signs.
// ----------------------------------------------------------------------------
package hex8_pkg;

    // fixed point scale of the result and internal arithmetic widths
    localparam int VALUE_FRAC_BITS = 16;
    localparam int LIMB_W          = 32;
    localparam int ACC_W           = 224;
    localparam int NUM_LIMBS       = ACC_W / LIMB_W;
    localparam int REM_W           = 142;
    localparam int NUM_FACTORS     = 4;

    // result table: address is {p, q, three sign bits}
    localparam int TBL_AW    = 7;
    localparam int TBL_DEPTH = 128;
    localparam int TBL_DW    = 65;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POISSON  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_X   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_Y   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_Z   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_EDGE = 3'd5;

    // error codes
    localparam logic [1:0] ERR_OK      = 2'd0;
    localparam logic [1:0] ERR_POISSON = 2'd1;
    localparam logic [1:0] ERR_EDGE    = 2'd2;

    localparam logic [16:0] ONE_Q16  = 17'd65536;
    localparam logic [4:0]  DOF_LAST = 5'd23;

    typedef struct packed {
        logic [4:0] row_dof;
        logic [4:0] col_dof;
    } req_t;

    typedef struct packed {
        logic signed [63:0] stiffness;
        logic [1:0]         error_code;
        logic               saturated;
    } res_t;

    typedef struct packed {
        logic [31:0] modulus_mpa;
        logic [15:0] poisson_q16;
        logic [31:0] edge_x_mm;
        logic [31:0] edge_y_mm;
        logic [31:0] edge_z_mm;
        logic [31:0] min_edge_mm;
    } cfg_t;

    typedef enum logic {
        KIND_TABLE,
        KIND_ZERO
    } entry_kind_t;

    typedef struct packed {
        entry_kind_t        kind;
        logic [TBL_AW-1:0]  addr;
        logic [1:0]         err;
    } q_entry_t;

    typedef struct packed {
        logic              we;
        logic [TBL_AW-1:0] addr;
        logic [TBL_DW-1:0] data;
    } tbl_wr_t;

    typedef enum logic [2:0] {
        BLD_LOAD,
        BLD_MUL,
        BLD_POST,
        BLD_DIV,
        BLD_WRITE,
        BLD_DONE
    } build_state_t;

    typedef enum logic [1:0] {
        PH_DEN,
        PH_TERM,
        PH_SCALE
    } build_phase_t;

    // 1 when the node's local coordinate along the axis is -1
    function automatic logic node_neg(input logic [1:0] axis, input logic [2:0] node);
        logic r;
        r = 1'b0;
        unique case (axis)
            2'd0:    r = node[1];
            2'd1:    r = ~(node[0] ^ node[1]);
            2'd2:    r = ~node[2];
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

@@ design/hex8_element_stiffness.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hex8_element_stiffness: one stiffness entry of an 8-node brick element
// An accepted beat passes the queue, the registered table read and the result
// register before done rises; one request per cycle sustained while busy is
// low, set by one result table read per cycle.
// After reset and after every config write busy stays high while the builder
// refills the 128-entry table (serial multiply and divide per entry). The
// receiver cannot stall; results leave on done.
// ----------------------------------------------------------------------------
module hex8_element_stiffness (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  hex8_pkg::req_t                     request,
    output logic                               done,
    output hex8_pkg::res_t                     result,
    input  logic                               cfg_we,
    input  logic [hex8_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [hex8_pkg::CFG_DATA_W-1:0]    cfg_data
);

    hex8_pkg::cfg_t     cfg_reg;
    hex8_pkg::tbl_wr_t  tbl_wr;
    hex8_pkg::q_entry_t push_entry, head;
    logic               table_ready;
    logic               push, pop, head_valid, queue_full;
    logic [hex8_pkg::TBL_AW-1:0] raddr;
    logic [hex8_pkg::TBL_DW-1:0] rdata;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.modulus_mpa <= 32'd200000;
            cfg_reg.poisson_q16 <= 16'd19661;
            cfg_reg.edge_x_mm   <= 32'd65536;
            cfg_reg.edge_y_mm   <= 32'd65536;
            cfg_reg.edge_z_mm   <= 32'd65536;
            cfg_reg.min_edge_mm <= 32'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                hex8_pkg::REG_MODULUS:  cfg_reg.modulus_mpa <= cfg_data;
                hex8_pkg::REG_POISSON:  cfg_reg.poisson_q16 <= cfg_data[15:0];
                hex8_pkg::REG_EDGE_X:   cfg_reg.edge_x_mm   <= cfg_data;
                hex8_pkg::REG_EDGE_Y:   cfg_reg.edge_y_mm   <= cfg_data;
                hex8_pkg::REG_EDGE_Z:   cfg_reg.edge_z_mm   <= cfg_data;
                hex8_pkg::REG_MIN_EDGE: cfg_reg.min_edge_mm <= cfg_data;
                default:                ;
            endcase
        end
    end

    // table builder
    hex8_build u_build (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .restart (cfg_we),
        .ready   (table_ready),
        .tbl_wr  (tbl_wr)
    );

    // result table
    hex8_ram #(
        .DATA_W (hex8_pkg::TBL_DW),
        .DEPTH  (hex8_pkg::TBL_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (tbl_wr.we),
        .waddr (tbl_wr.addr),
        .wdata (tbl_wr.data),
        .raddr (raddr),
        .rdata (rdata)
    );

    // front end
    hex8_front u_front (
        .start       (start),
        .request     (request),
        .cfg         (cfg_reg),
        .table_ready (table_ready),
        .queue_full  (queue_full),
        .busy        (busy),
        .push        (push),
        .push_entry  (push_entry)
    );

    // queue between front and back
    hex8_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .valid      (head_valid),
        .full       (queue_full),
        .head       (head)
    );

    // back end
    hex8_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .raddr      (raddr),
        .rdata      (rdata),
        .done       (done),
        .result     (result)
    );

endmodule

@@ design/hex8_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hex8_ram: generic single write, single read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module hex8_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ design/hex8_build.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hex8_build: result table builder
// Sweeps all table addresses; per entry forms the exact rational value with a
// limb-serial multiplier and a one-bit-per-cycle restoring divider.
// ----------------------------------------------------------------------------
module hex8_build (
    input  logic             clk,
    input  logic             rst_n,
    input  hex8_pkg::cfg_t   cfg,
    input  logic             restart,
    output logic             ready,
    output hex8_pkg::tbl_wr_t tbl_wr
);

    localparam int AW  = hex8_pkg::ACC_W;
    localparam int LW  = hex8_pkg::LIMB_W;
    localparam int RW  = hex8_pkg::REM_W;
    localparam int NF  = hex8_pkg::NUM_FACTORS;
    localparam int TAW = hex8_pkg::TBL_AW;
    localparam int LCW = $clog2(hex8_pkg::NUM_LIMBS);
    localparam int SCW = $clog2(AW);
    localparam int FCW = $clog2(NF + 1);

    hex8_pkg::build_state_t state_reg, state_next;
    hex8_pkg::build_phase_t phase_reg, phase_next;

    logic [TAW-1:0] addr_reg, addr_next;
    logic [1:0]     k_reg, k_next;
    logic [AW-1:0]  t_reg, t_next;
    logic [AW-1:0]  s_reg, s_next;
    logic [RW-1:0]  dv_reg, dv_next;
    logic [LW-1:0]  fac_reg [NF];
    logic [LW-1:0]  fac_next [NF];
    logic [FCW-1:0] fcnt_reg, fcnt_next;
    logic [LCW-1:0] limb_reg, limb_next;
    logic [LW-1:0]  carry_reg, carry_next;
    logic           tneg_reg, tneg_next;
    logic [AW-1:0]  n_reg, n_next;
    logic [RW-1:0]  rem_reg, rem_next;
    logic [63:0]    quo_reg, quo_next;
    logic           hi_reg, hi_next;
    logic           neg_reg, neg_next;
    logic [SCW-1:0] step_reg, step_next;
    logic           ready_reg, ready_next;

    // entry decode
    logic [1:0]  p, q, f, o1, o2;
    logic        diag;
    logic [31:0] hv [3];
    logic [16:0] plus, minus2, one_minus;
    logic [17:0] wgt;
    logic [2:0]  shamt;
    logic signed [19:0] n1;
    logic [18:0] an;
    logic [25:0] den_init;
    logic [63:0] prod;
    logic [RW-1:0] r2, d2;
    logic        ge;
    logic        sat;
    logic [63:0] value;

    assign p    = addr_reg[6:5];
    assign q    = addr_reg[4:3];
    assign diag = (p == q);
    assign f    = 2'd3 - p - q;
    assign o1   = (k_reg == 2'd0) ? 2'd1 : 2'd0;
    assign o2   = (k_reg == 2'd2) ? 2'd1 : 2'd2;
    assign hv[0] = cfg.edge_x_mm;
    assign hv[1] = cfg.edge_y_mm;
    assign hv[2] = cfg.edge_z_mm;

    // material terms
    assign plus      = hex8_pkg::ONE_Q16 + {1'b0, cfg.poisson_q16};
    assign minus2    = hex8_pkg::ONE_Q16 - {cfg.poisson_q16, 1'b0};
    assign one_minus = hex8_pkg::ONE_Q16 - {1'b0, cfg.poisson_q16};
    assign wgt       = (k_reg == p) ? {one_minus, 1'b0} : {1'b0, minus2};
    // 3+s is 4 for a plus sign, 2 for a minus sign
    assign shamt     = (addr_reg[o1] ? 3'd1 : 3'd2) + (addr_reg[o2] ? 3'd1 : 3'd2);
    assign n1 = (addr_reg[1] ? -$signed({3'b0, cfg.poisson_q16, 1'b0})
                             :  $signed({3'b0, cfg.poisson_q16, 1'b0}))
              + (addr_reg[0] ? -$signed({3'b0, minus2}) : $signed({3'b0, minus2}));
    assign an = n1[19] ? 19'(-n1) : n1[18:0];
    assign den_init = (diag ? 26'd288 : 26'd96) * 26'(plus);

    // limb step and divider step
    assign prod = 64'(t_reg[LW-1:0]) * 64'(fac_reg[0]) + 64'(carry_reg);
    assign r2   = {rem_reg[RW-2:0], n_reg[AW-1]};
    assign d2   = {dv_reg[RW-2:0], 1'b0};
    assign ge   = (r2 >= d2);

    // saturation of the rounded magnitude
    always_comb
    begin
        if (neg_reg)
        begin
            sat   = hi_reg | (quo_reg[63] & (|quo_reg[62:0]));
            value = sat ? 64'h8000_0000_0000_0000 : (64'd0 - quo_reg);
        end
        else
        begin
            sat   = hi_reg | quo_reg[63];
            value = sat ? 64'h7FFF_FFFF_FFFF_FFFF : quo_reg;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hex8_pkg::BLD_LOAD:  state_next = hex8_pkg::BLD_MUL;
            hex8_pkg::BLD_MUL:
            begin
                if (limb_reg == LCW'(hex8_pkg::NUM_LIMBS - 1) && fcnt_reg == FCW'(1))
                begin
                    state_next = hex8_pkg::BLD_POST;
                end
            end
            hex8_pkg::BLD_POST:
            begin
                state_next = (phase_reg == hex8_pkg::PH_SCALE) ? hex8_pkg::BLD_DIV
                                                                : hex8_pkg::BLD_LOAD;
            end
            hex8_pkg::BLD_DIV:
            begin
                if (step_reg == SCW'(AW - 1))
                begin
                    state_next = hex8_pkg::BLD_WRITE;
                end
            end
            hex8_pkg::BLD_WRITE:
            begin
                state_next = (addr_reg == TAW'(hex8_pkg::TBL_DEPTH - 1))
                           ? hex8_pkg::BLD_DONE : hex8_pkg::BLD_LOAD;
            end
            hex8_pkg::BLD_DONE:  state_next = hex8_pkg::BLD_DONE;
            default:             state_next = hex8_pkg::BLD_LOAD;
        endcase
        if (restart)
        begin
            state_next = hex8_pkg::BLD_LOAD;
        end
    end

    // datapath
    always_comb
    begin
        phase_next = phase_reg;
        addr_next  = addr_reg;
        k_next     = k_reg;
        t_next     = t_reg;
        s_next     = s_reg;
        dv_next    = dv_reg;
        fac_next   = fac_reg;
        fcnt_next  = fcnt_reg;
        limb_next  = limb_reg;
        carry_next = carry_reg;
        tneg_next  = tneg_reg;
        n_next     = n_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        hi_next    = hi_reg;
        neg_next   = neg_reg;
        step_next  = step_reg;
        ready_next = ready_reg;
        unique case (state_reg)
            hex8_pkg::BLD_LOAD:
            begin
                limb_next  = '0;
                carry_next = '0;
                unique case (phase_reg)
                    hex8_pkg::PH_DEN:
                    begin
                        t_next      = AW'(den_init);
                        fac_next[0] = LW'(minus2);
                        fac_next[1] = hv[0];
                        fac_next[2] = hv[1];
                        fac_next[3] = hv[2];
                        fcnt_next   = diag ? FCW'(4) : FCW'(1);
                    end
                    hex8_pkg::PH_TERM:
                    begin
                        if (diag)
                        begin
                            t_next      = AW'(wgt) << shamt;
                            fac_next[0] = hv[o1];
                            fac_next[1] = hv[o1];
                            fac_next[2] = hv[o2];
                            fac_next[3] = hv[o2];
                            fcnt_next   = FCW'(4);
                            tneg_next   = addr_reg[k_reg];
                        end
                        else
                        begin
                            t_next      = AW'(an) << (addr_reg[2] ? 1 : 2);
                            fac_next[0] = hv[f];
                            fcnt_next   = FCW'(1);
                            tneg_next   = n1[19];
                        end
                    end
                    default:
                    begin
                        neg_next    = s_reg[AW-1];
                        t_next      = s_reg[AW-1] ? (AW'(0) - s_reg) : s_reg;
                        fac_next[0] = cfg.modulus_mpa;
                        fcnt_next   = FCW'(1);
                    end
                endcase
            end
            hex8_pkg::BLD_MUL:
            begin
                t_next     = {prod[LW-1:0], t_reg[AW-1:LW]};
                carry_next = prod[63:LW];
                limb_next  = limb_reg + LCW'(1);
                if (limb_reg == LCW'(hex8_pkg::NUM_LIMBS - 1))
                begin
                    limb_next  = '0;
                    carry_next = '0;
                    fcnt_next  = fcnt_reg - FCW'(1);
                    for (int i = 0; i < NF - 1; i++)
                    begin
                        fac_next[i] = fac_reg[i + 1];
                    end
                end
            end
            hex8_pkg::BLD_POST:
            begin
                unique case (phase_reg)
                    hex8_pkg::PH_DEN:
                    begin
                        dv_next    = t_reg[RW-1:0];
                        s_next     = '0;
                        k_next     = 2'd0;
                        phase_next = hex8_pkg::PH_TERM;
                    end
                    hex8_pkg::PH_TERM:
                    begin
                        s_next = tneg_reg ? (s_reg - t_reg) : (s_reg + t_reg);
                        if (diag && k_reg != 2'd2)
                        begin
                            k_next = k_reg + 2'd1;
                        end
                        else
                        begin
                            phase_next = hex8_pkg::PH_SCALE;
                        end
                    end
                    default:
                    begin
                        // twice the numerator plus the divisor gives rounding
                        n_next    = (t_reg << (hex8_pkg::VALUE_FRAC_BITS + 1)) + AW'(dv_reg);
                        rem_next  = '0;
                        quo_next  = '0;
                        hi_next   = 1'b0;
                        step_next = '0;
                    end
                endcase
            end
            hex8_pkg::BLD_DIV:
            begin
                rem_next  = ge ? (r2 - d2) : r2;
                quo_next  = {quo_reg[62:0], ge};
                hi_next   = hi_reg | quo_reg[63];
                n_next    = {n_reg[AW-2:0], 1'b0};
                step_next = step_reg + SCW'(1);
            end
            hex8_pkg::BLD_WRITE:
            begin
                phase_next = hex8_pkg::PH_DEN;
                addr_next  = addr_reg + TAW'(1);
                if (addr_reg == TAW'(hex8_pkg::TBL_DEPTH - 1))
                begin
                    ready_next = 1'b1;
                end
            end
            default:
            begin
                ready_next = 1'b1;
            end
        endcase
        if (restart)
        begin
            phase_next = hex8_pkg::PH_DEN;
            addr_next  = '0;
            ready_next = 1'b0;
        end
    end

    // table write port
    always_comb
    begin
        tbl_wr.we   = (state_reg == hex8_pkg::BLD_WRITE) && !restart;
        tbl_wr.addr = addr_reg;
        tbl_wr.data = {sat, value};
    end

    assign ready = ready_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hex8_pkg::BLD_LOAD;
            phase_reg <= hex8_pkg::PH_DEN;
            addr_reg  <= '0;
            k_reg     <= '0;
            fcnt_reg  <= '0;
            limb_reg  <= '0;
            step_reg  <= '0;
            ready_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            addr_reg  <= addr_next;
            k_reg     <= k_next;
            fcnt_reg  <= fcnt_next;
            limb_reg  <= limb_next;
            step_reg  <= step_next;
            ready_reg <= ready_next;
        end
    end

    // arithmetic registers
    always_ff @(posedge clk)
    begin
        t_reg     <= t_next;
        s_reg     <= s_next;
        dv_reg    <= dv_next;
        fac_reg   <= fac_next;
        carry_reg <= carry_next;
        tneg_reg  <= tneg_next;
        n_reg     <= n_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        hi_reg    <= hi_next;
        neg_reg   <= neg_next;
    end

endmodule

@@ design/hex8_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hex8_front: request acceptance and classification
// Checks the configuration for errors and maps a row/column pair to an entry
// of the result table.
// ----------------------------------------------------------------------------
module hex8_front (
    input  logic               start,
    input  hex8_pkg::req_t     request,
    input  hex8_pkg::cfg_t     cfg,
    input  logic               table_ready,
    input  logic               queue_full,
    output logic               busy,
    output logic               push,
    output hex8_pkg::q_entry_t push_entry
);

    logic [8:0] r_mul, c_mul;
    logic [2:0] na, nb;
    logic [1:0] p, q, f;
    logic [2:0] s;
    logic       s1, s2;
    logic       edge_bad;
    logic       out_of_range;

    assign busy = !table_ready || queue_full;
    assign push = start && !busy;

    // node = dof / 3 via multiply by 11 over 32 (exact up to 23)
    assign r_mul = 9'(request.row_dof) * 9'd11;
    assign c_mul = 9'(request.col_dof) * 9'd11;
    assign na    = r_mul[7:5];
    assign nb    = c_mul[7:5];
    assign p     = 2'(request.row_dof - 5'(na) * 5'd3);
    assign q     = 2'(request.col_dof - 5'(nb) * 5'd3);
    assign f     = 2'd3 - p - q;

    // sign products between the two nodes
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s[i] = hex8_pkg::node_neg(2'(i), na) ^ hex8_pkg::node_neg(2'(i), nb);
        end
    end
    assign s1 = hex8_pkg::node_neg(p, na) ^ hex8_pkg::node_neg(q, nb);
    assign s2 = hex8_pkg::node_neg(q, na) ^ hex8_pkg::node_neg(p, nb);

    assign edge_bad = (cfg.edge_x_mm == 32'd0) || (cfg.edge_x_mm < cfg.min_edge_mm)
                   || (cfg.edge_y_mm == 32'd0) || (cfg.edge_y_mm < cfg.min_edge_mm)
                   || (cfg.edge_z_mm == 32'd0) || (cfg.edge_z_mm < cfg.min_edge_mm);
    assign out_of_range = (request.row_dof > hex8_pkg::DOF_LAST)
                       || (request.col_dof > hex8_pkg::DOF_LAST);

    // classify the beat
    always_comb
    begin
        push_entry.kind = hex8_pkg::KIND_TABLE;
        push_entry.err  = hex8_pkg::ERR_OK;
        if (p == q)
        begin
            push_entry.addr = {p, q, s[2], s[1], s[0]};
        end
        else
        begin
            push_entry.addr = {p, q, s[f], s1, s2};
        end
        priority if (cfg.poisson_q16[15])
        begin
            push_entry.kind = hex8_pkg::KIND_ZERO;
            push_entry.err  = hex8_pkg::ERR_POISSON;
        end
        else if (edge_bad)
        begin
            push_entry.kind = hex8_pkg::KIND_ZERO;
            push_entry.err  = hex8_pkg::ERR_EDGE;
        end
        else if (out_of_range)
        begin
            push_entry.kind = hex8_pkg::KIND_ZERO;
        end
        else
        begin
            push_entry.kind = hex8_pkg::KIND_TABLE;
        end
    end

endmodule

@@ design/hex8_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hex8_queue: two-entry queue between front and back
// Holds classified beats until the back end takes them.
// ----------------------------------------------------------------------------
module hex8_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  hex8_pkg::q_entry_t push_entry,
    input  logic               pop,
    output logic               valid,
    output logic               full,
    output hex8_pkg::q_entry_t head
);

    hex8_pkg::q_entry_t ent_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign valid   = (count_reg != 2'd0);
    assign full    = (count_reg == 2'd2);
    assign head    = ent_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb
    begin
        count_next = count_reg + 2'(do_push) - 2'(do_pop);
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            ent_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

@@ design/hex8_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hex8_back: table lookup and result output
// Reads the result table for each queued beat and registers the result.
// ----------------------------------------------------------------------------
module hex8_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            head_valid,
    input  hex8_pkg::q_entry_t              head,
    output logic                            pop,
    output logic [hex8_pkg::TBL_AW-1:0]     raddr,
    input  logic [hex8_pkg::TBL_DW-1:0]     rdata,
    output logic                            done,
    output hex8_pkg::res_t                  result
);

    logic                 s1_valid_reg;
    hex8_pkg::entry_kind_t s1_kind_reg;
    logic [1:0]           s1_err_reg;
    logic                 done_reg;
    hex8_pkg::res_t       result_reg, result_next;

    assign pop   = head_valid;
    assign raddr = head.addr;

    // result select
    always_comb
    begin
        if (s1_kind_reg == hex8_pkg::KIND_TABLE)
        begin
            result_next.stiffness  = rdata[63:0];
            result_next.error_code = hex8_pkg::ERR_OK;
            result_next.saturated  = rdata[64];
        end
        else
        begin
            result_next.stiffness  = '0;
            result_next.error_code = s1_err_reg;
            result_next.saturated  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= head_valid;
            done_reg     <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_kind_reg <= head.kind;
        s1_err_reg  <= head.err;
        result_reg  <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

@@ tb/sv/hex8_stiffness_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hex8_stiffness_checker: result predictor and scoreboard for the brick block
// Tracks register writes, predicts each accepted request exactly from the
// register values, and compares every result beat against the oldest entry.
// ----------------------------------------------------------------------------
module hex8_stiffness_checker
    import hex8_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  req_t                  request,
    input  logic                  done,
    input  res_t                  result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    errors,
    output int                    pending
);

    typedef logic [255:0] wide_t;

    // +1/-1 local coordinate of each node along ksi, etta, psi
    int node_sgn [3][8] = '{
        '{ 1,  1, -1, -1,  1,  1, -1, -1},
        '{-1,  1,  1, -1, -1,  1,  1, -1},
        '{-1, -1, -1, -1,  1,  1,  1,  1}
    };

    cfg_t regs;
    res_t entry_q[$];

    assign pending = entry_q.size();

    // exact rational entry, rounded half away from zero, then saturated
    function automatic res_t stiffness_entry(input req_t rq, input cfg_t c);
        res_t        r;
        wide_t       pos, neg, term, den, num, quo, rem;
        logic [31:0] h [3];
        int          na, nb, p, q, f, k, o, s1, s2;
        int          s [3];
        longint      pr, plus, minus2, n1;
        logic [63:0] mag;
        logic        negv, big;
        r = '0;
        h[0] = c.edge_x_mm;
        h[1] = c.edge_y_mm;
        h[2] = c.edge_z_mm;
        pr = c.poisson_q16;
        if (pr >= 32768) begin
            r.error_code = ERR_POISSON;
            return r;
        end
        for (k = 0; k < 3; k++)
        begin
            if (h[k] == 0 || h[k] < c.min_edge_mm) begin
                r.error_code = ERR_EDGE;
                return r;
            end
        end
        if (rq.row_dof > DOF_LAST || rq.col_dof > DOF_LAST)
            return r;
        na = rq.row_dof / 3;
        p  = rq.row_dof % 3;
        nb = rq.col_dof / 3;
        q  = rq.col_dof % 3;
        plus   = 65536 + pr;
        minus2 = 65536 - 2 * pr;
        for (k = 0; k < 3; k++)
            s[k] = node_sgn[k][na] * node_sgn[k][nb];
        pos = '0;
        neg = '0;
        if (p == q) begin
            // normal-normal block: one term per strain direction
            for (k = 0; k < 3; k++)
            begin
                term = (k == p) ? wide_t'(2 * (65536 - pr)) : wide_t'(minus2);
                for (o = 0; o < 3; o++)
                begin
                    if (o != k)
                        term = term * wide_t'(3 + s[o]) * wide_t'(h[o]) * wide_t'(h[o]);
                end
                if (s[k] > 0)
                    pos = pos + term;
                else
                    neg = neg + term;
            end
            den = wide_t'(288) * wide_t'(plus) * wide_t'(minus2)
                * wide_t'(h[0]) * wide_t'(h[1]) * wide_t'(h[2]);
        end
        else begin
            // coupling block: Poisson and shear parts share the free axis
            f  = 3 - p - q;
            s1 = node_sgn[p][na] * node_sgn[q][nb];
            s2 = node_sgn[q][na] * node_sgn[p][nb];
            n1 = s1 * 2 * pr + s2 * minus2;
            term = wide_t'(n1 < 0 ? -n1 : n1) * wide_t'(h[f]) * wide_t'(3 + s[f]);
            if (n1 < 0)
                neg = term;
            else
                pos = term;
            den = wide_t'(96) * wide_t'(plus) * wide_t'(minus2);
        end
        negv = neg > pos;
        num  = negv ? neg - pos : pos - neg;
        num  = (num * wide_t'(c.modulus_mpa)) << VALUE_FRAC_BITS;
        quo  = num / den;
        rem  = num % den;
        if ((rem << 1) >= den)
            quo = quo + 1;
        big = |quo[255:64];
        mag = quo[63:0];
        if (negv) begin
            if (big || mag > 64'h8000_0000_0000_0000) begin
                r.stiffness = 64'h8000_0000_0000_0000;
                r.saturated = 1'b1;
            end
            else
                r.stiffness = -mag;
        end
        else begin
            if (big || mag > 64'h7FFF_FFFF_FFFF_FFFF) begin
                r.stiffness = 64'h7FFF_FFFF_FFFF_FFFF;
                r.saturated = 1'b1;
            end
            else
                r.stiffness = mag;
        end
        return r;
    endfunction

    // register shadow, prediction on accept, compare on each result beat
    always @(posedge clk or negedge rst_n)
    begin
        res_t exp_res;
        if (!rst_n) begin
            regs <= '{modulus_mpa: 32'd200000, poisson_q16: 16'd19661,
                      edge_x_mm: 32'd65536, edge_y_mm: 32'd65536,
                      edge_z_mm: 32'd65536, min_edge_mm: 32'd1};
            errors <= 0;
            entry_q.delete();
        end
        else begin
            if (done) begin
                if (entry_q.size() == 0) begin
                    $display("%0t: result beat with nothing expected, actual %h",
                             $time, result);
                    errors <= errors + 1;
                end
                else begin
                    exp_res = entry_q.pop_front();
                    if (exp_res.stiffness !== result.stiffness
                        || exp_res.error_code !== result.error_code
                        || exp_res.saturated !== result.saturated) begin
                        $display("%0t: mismatch stiffness exp %0d act %0d, err exp %0d act %0d, sat exp %0d act %0d",
                                 $time, exp_res.stiffness, result.stiffness,
                                 exp_res.error_code, result.error_code,
                                 exp_res.saturated, result.saturated);
                        errors <= errors + 1;
                    end
                end
            end
            if (start && !busy)
                entry_q.push_back(stiffness_entry(request, regs));
            if (cfg_we) begin
                case (cfg_index)
                    REG_MODULUS:  regs.modulus_mpa <= cfg_data;
                    REG_POISSON:  regs.poisson_q16 <= cfg_data[15:0];
                    REG_EDGE_X:   regs.edge_x_mm   <= cfg_data;
                    REG_EDGE_Y:   regs.edge_y_mm   <= cfg_data;
                    REG_EDGE_Z:   regs.edge_z_mm   <= cfg_data;
                    REG_MIN_EDGE: regs.min_edge_mm <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

@@ tb/sv/tb_hex8_element_stiffness.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hex8_element_stiffness: stimulus and verdict for the brick element block
// Runs a series of register settings (defaults, error cases, saturation,
// extremes, random), streams entry requests with random idle bursts, and
// relies on the checker for predicting and comparing results.
// ----------------------------------------------------------------------------
module tb_hex8_element_stiffness;
    import hex8_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int QUIET_LIMIT = 400000;
    localparam int NO_IDLE_FROM = 1600;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    req_t                  request;
    logic                  done;
    res_t                  result;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    errors;
    int                    pending;
    int                    sent;
    int                    quiet;

    hex8_element_stiffness dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .request(request),
        .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    hex8_stiffness_checker u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .request(request),
        .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .errors(errors), .pending(pending)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // watchdog on cycles with no beat on either side
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("tb_hex8_element_stiffness failed");
            $finish;
        end
    end

    // one request beat, after an optional idle burst
    task automatic send_entry(input int row, input int col);
        int gap;
        gap = (sent < NO_IDLE_FROM && $urandom_range(0, 3) == 0) ? $urandom_range(1, 19) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        request <= '{row_dof: 5'(row), col_dof: 5'(col)};
        do
            @(posedge clk);
        while (busy);
        sent++;
    endtask

    task automatic send_random(input int n);
        int i;
        for (i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 6) != 0)
                send_entry($urandom_range(0, 23), $urandom_range(0, 23));
            else
                send_entry($urandom_range(0, 31), $urandom_range(0, 31));
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    // drain, then load a full register set and let the table rebuild begin
    task automatic load_setting(input logic [31:0] e, input logic [31:0] pr,
                                input logic [31:0] hx, input logic [31:0] hy,
                                input logic [31:0] hz, input logic [31:0] hmin);
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        write_reg(REG_MODULUS, e);
        write_reg(REG_POISSON, pr);
        write_reg(REG_EDGE_X, hx);
        write_reg(REG_EDGE_Y, hy);
        write_reg(REG_EDGE_Z, hz);
        write_reg(REG_MIN_EDGE, hmin);
        write_reg(REG_UNUSED, $urandom);
        cfg_we <= 1'b0;
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        int d, k;
        int dir_row [22] = '{0, 23, 0, 23, 1, 2, 0, 4, 7, 5, 24, 0, 31, 31,
                             12, 22, 10, 11, 3, 6, 14, 19};
        int dir_col [22] = '{0, 23, 23, 0, 2, 1, 1, 5, 2, 9, 0, 24, 31, 0,
                             17, 3, 10, 11, 6, 3, 20, 8};
        rst_n = 1'b0;
        start = 1'b0;
        request = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        sent = 0;
        quiet = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // reset values, directed corners of the matrix
        for (d = 0; d < 22; d++)
            send_entry(dir_row[d], dir_col[d]);
        send_random(130);

        // largest modulus and edges: saturation
        load_setting(32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        send_random(130);
        // Poisson ratio just under one half
        load_setting(32'hFFFF_FFFF, 32767, 32'h0001_0000, 32'h0002_0000, 32'h0000_8000, 1);
        send_random(130);
        // Poisson ratio error, checked ahead of a zero edge
        load_setting(1000, 32768, 0, 32'h0001_0000, 32'h0001_0000, 0);
        send_random(60);
        load_setting(1000, 65535, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1);
        send_random(60);
        // zero edge with no minimum, then an edge below the minimum
        load_setting(70000, 21000, 32'h0003_0000, 0, 32'h0001_0000, 0);
        send_random(60);
        load_setting(70000, 21000, 32'h0003_0000, 32'h0002_0000, 32'h0000_FFFF,
                     32'h0001_0000);
        send_random(60);
        // edges equal to the minimum, smallest nonzero edges
        load_setting(210000, 19661, 12345, 12345, 12345, 12345);
        send_random(130);
        load_setting(32'hFFFF_FFFF, 1, 1, 1, 1, 1);
        send_random(130);
        // zero modulus
        load_setting(0, 10000, 32'h0005_0000, 32'h0001_0000, 32'h0000_1000, 0);
        send_random(100);
        // random settings
        for (k = 0; k < 6; k++)
        begin
            load_setting($urandom, $urandom_range(0, 32767), $urandom_range(1, 32'h00FF_FFFF),
                         $urandom, $urandom_range(1, 32'h0010_0000), $urandom_range(0, 1000));
            send_random(140);
        end
        start <= 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("tb_hex8_element_stiffness passed");
        else
            $display("tb_hex8_element_stiffness failed");
        $finish;
    end

endmodule
